// File: hdl/utcd_pkg.sv
// shared types, constants and character codes for the text command decoder
package utcd_pkg;

    // default sizes
    localparam int LINE_LENGTH_DEF = 20;
    localparam int LED_COUNT_DEF   = 8;

    // register reset values and limits
    localparam logic [15:0] TPS_RESET  = 16'd31250;
    localparam logic [3:0]  MAXS_RESET = 4'd5;
    localparam logic [6:0]  NUM_SAT    = 7'd99;

    // register indexes
    localparam logic CFG_TPS  = 1'b0;
    localparam logic CFG_MAXS = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;

    // "set time" prefix, first character at index 0
    localparam logic [7:0] SET_WORD [8] = '{8'h73, 8'h65, 8'h74, 8'h20,
                                            8'h74, 8'h69, 8'h6D, 8'h65};
    localparam int SET_LEN    = 8;
    localparam int NUM_OFFSET = 9;

    // one queued byte with its class
    typedef struct packed {
        logic       eol;
        logic [7:0] data;
    } t_item;

    // back end sequencer
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_DONE
    } t_bstate;

    // number reader phase
    typedef enum logic [1:0] {
        NP_SKIP,
        NP_DIGIT,
        NP_STOP
    } t_nphase;

endpackage

// File: hdl/utcd_front.sv
// front end: takes received bytes, marks line ends and queues them
module utcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_rx_byte,
    output logic          o_q_valid,
    output utcd_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import utcd_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;

    // classify the incoming byte
    always_comb begin
        w_item.data = i_rx_byte;
        w_item.eol  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: hdl/utcd_back.sv
// back end: line store, end-of-line walk, led and timer decode, result register
module utcd_back #(
    parameter int LINE_LENGTH = utcd_pkg::LINE_LENGTH_DEF,
    parameter int LED_COUNT   = utcd_pkg::LED_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  utcd_pkg::t_item i_q_item,
    output logic            o_q_pop,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_echo_byte,
    output logic [7:0]      o_led_pins,
    output logic [19:0]     o_compare_value,
    output logic            o_compare_written,
    output logic            o_line_done
);
    import utcd_pkg::*;

    localparam int DEPTH = LINE_LENGTH - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(LINE_LENGTH);

    t_bstate r_state, n_state;

    logic [7:0]           r_store [DEPTH];
    logic [7:0]           r_rd_data;
    logic                 r_rd_vld;
    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        r_addr;
    logic [FW-1:0]        r_len;
    logic                 r_stop;
    logic [63:0]          r_win;
    logic [LED_COUNT-1:0] r_on;
    logic [LED_COUNT-1:0] r_off;
    logic [LED_COUNT-1:0] r_led;
    logic                 r_set_ok;
    t_nphase              r_phase;
    logic                 r_neg;
    logic [6:0]           r_acc;
    logic [7:0]           r_eol_byte;
    logic [15:0]          r_tps;
    logic [3:0]           r_maxs;
    logic [19:0]          r_period;

    logic                 w_out_free;
    logic                 w_take;
    logic                 w_wr;
    logic                 w_issue;
    logic                 w_proc;
    logic [7:0]           w_b;
    logic [63:0]          w_win;
    logic                 w_on_base;
    logic                 w_off_base;
    logic [LED_COUNT-1:0] w_on_hit;
    logic [LED_COUNT-1:0] w_off_hit;
    logic                 w_blank;
    logic                 w_digit;
    logic [9:0]           w_acc_sum;
    logic [6:0]           w_acc_n;
    logic [6:0]           w_secs;
    logic [3:0]           w_clamp;
    logic [19:0]          w_product;
    logic                 w_set_line;
    logic                 w_finish;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_take     = (r_state == BS_IDLE) && i_q_valid && w_out_free;
    assign o_q_pop    = w_take;
    assign w_wr       = w_take && !i_q_item.eol && (r_fill < FW'(DEPTH));
    assign w_issue    = (r_state == BS_SCAN) && (r_addr < r_fill);
    assign w_proc     = (r_state == BS_SCAN) && r_rd_vld && !r_stop;
    assign w_finish   = (r_state == BS_DONE) && w_out_free;

    // line store memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[r_fill[AW-1:0]] <= i_q_item.data;
        end
        if (w_issue) begin
            r_rd_data <= r_store[r_addr[AW-1:0]];
        end
    end

    // pattern windows over the last eight bytes, newest in the low byte
    always_comb begin
        w_b        = r_rd_data;
        w_win      = {r_win[55:0], w_b};
        w_on_base  = (w_win[55:48] == CH_L) && (w_win[47:40] == CH_E) &&
                     (w_win[39:32] == CH_D) && (w_win[23:16] == CH_SPACE) &&
                     (w_win[15:8] == CH_O) && (w_win[7:0] == CH_N);
        w_off_base = (w_win[63:56] == CH_L) && (w_win[55:48] == CH_E) &&
                     (w_win[47:40] == CH_D) && (w_win[31:24] == CH_SPACE) &&
                     (w_win[23:16] == CH_O) && (w_win[15:8] == CH_F) &&
                     (w_win[7:0] == CH_F);
        for (int n = 0; n < LED_COUNT; n++) begin
            w_on_hit[n]  = w_on_base && (w_win[31:24] == 8'(CH_ONE + 8'(n)));
            w_off_hit[n] = w_off_base && (w_win[39:32] == 8'(CH_ONE + 8'(n)));
        end
    end

    // number reader step
    always_comb begin
        w_blank   = (w_b == CH_SPACE) || ((w_b >= CH_TAB) && (w_b <= CH_CR));
        w_digit   = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
        w_acc_sum = 10'(r_acc) * 10'd10 + 10'(w_b - CH_ZERO);
        w_acc_n   = (w_acc_sum > 10'(NUM_SAT)) ? NUM_SAT : w_acc_sum[6:0];
    end

    // clamp and scale to timer ticks
    always_comb begin
        w_secs     = r_neg ? 7'd0 : r_acc;
        w_clamp    = (w_secs > 7'(r_maxs)) ? r_maxs : w_secs[3:0];
        w_product  = 20'(w_clamp) * 20'(r_tps);
        w_set_line = r_set_ok && (r_len >= FW'(SET_LEN));
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (w_take && i_q_item.eol) begin
                    n_state = BS_SCAN;
                end
            end
            BS_SCAN: begin
                if (!w_issue && !r_rd_vld) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (w_out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps  <= TPS_RESET;
            r_maxs <= MAXS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TPS) begin
                r_tps <= i_cfg_data;
            end else begin
                r_maxs <= i_cfg_data[3:0];
            end
        end
    end

    // line state and walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_led    <= '0;
            r_period <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_wr) begin
                r_fill <= r_fill + FW'(1);
            end
            if (w_issue) begin
                r_addr <= r_addr + FW'(1);
            end
            if (w_take && i_q_item.eol) begin
                r_addr     <= '0;
                r_len      <= '0;
                r_stop     <= 1'b0;
                r_win      <= '0;
                r_on       <= '0;
                r_off      <= '0;
                r_set_ok   <= 1'b1;
                r_phase    <= NP_SKIP;
                r_neg      <= 1'b0;
                r_acc      <= '0;
                r_eol_byte <= i_q_item.data;
            end
            if (w_proc) begin
                if (w_b == CH_NUL) begin
                    r_stop <= 1'b1;
                end else begin
                    r_len <= r_len + FW'(1);
                    r_win <= w_win;
                    r_on  <= r_on | w_on_hit;
                    r_off <= r_off | w_off_hit;
                    if ((r_len < FW'(SET_LEN)) && (w_b != SET_WORD[r_len[2:0]])) begin
                        r_set_ok <= 1'b0;
                    end
                    if (r_len >= FW'(NUM_OFFSET)) begin
                        case (r_phase)
                            NP_SKIP: begin
                                if (w_blank) begin
                                    r_phase <= NP_SKIP;
                                end else if ((w_b == CH_PLUS) || (w_b == CH_MINUS)) begin
                                    r_neg   <= (w_b == CH_MINUS);
                                    r_phase <= NP_DIGIT;
                                end else if (w_digit) begin
                                    r_acc   <= w_acc_n;
                                    r_phase <= NP_DIGIT;
                                end else begin
                                    r_phase <= NP_STOP;
                                end
                            end
                            NP_DIGIT: begin
                                if (w_digit) begin
                                    r_acc <= w_acc_n;
                                end else begin
                                    r_phase <= NP_STOP;
                                end
                            end
                            default: r_phase <= NP_STOP;
                        endcase
                    end
                end
            end
            if (w_finish) begin
                r_led  <= (r_led | r_on) & ~r_off;
                r_fill <= '0;
                if (w_set_line) begin
                    r_period <= w_product;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_take && !i_q_item.eol) begin
            o_out_valid       <= 1'b1;
            o_echo_byte       <= i_q_item.data;
            o_led_pins        <= 8'(r_led);
            o_compare_value   <= r_period;
            o_compare_written <= 1'b0;
            o_line_done       <= 1'b0;
        end else if (w_finish) begin
            o_out_valid       <= 1'b1;
            o_echo_byte       <= r_eol_byte;
            o_led_pins        <= 8'((r_led | r_on) & ~r_off);
            o_compare_value   <= w_set_line ? w_product : r_period;
            o_compare_written <= w_set_line;
            o_line_done       <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/uart_text_command_decoder.sv
// top level of the text command decoder: byte front end, queue and line back end
//
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_rx_byte
// out      output     o_out_valid / i_out_stall o_echo_byte, o_led_pins,
//                                               o_compare_value, o_compare_written,
//                                               o_line_done
// cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// an ordinary byte passes through the queue and then into the result register
// a CR or LF walks the line store one byte a cycle through its single read port
// a two-entry queue takes up to two bytes while a line is walked
// synchronous active-low reset empties the line and clears leds and period
module uart_text_command_decoder #(
    parameter int LINE_LENGTH = utcd_pkg::LINE_LENGTH_DEF,
    parameter int LED_COUNT   = utcd_pkg::LED_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_echo_byte,
    output logic [7:0]  o_led_pins,
    output logic [19:0] o_compare_value,
    output logic        o_compare_written,
    output logic        o_line_done
);
    import utcd_pkg::*;

    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;

    // byte intake and queue
    utcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    // line handling and results
    utcd_back #(
        .LINE_LENGTH (LINE_LENGTH),
        .LED_COUNT   (LED_COUNT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_q_pop),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_echo_byte       (o_echo_byte),
        .o_led_pins        (o_led_pins),
        .o_compare_value   (o_compare_value),
        .o_compare_written (o_compare_written),
        .o_line_done       (o_line_done)
    );

endmodule
